FILE: design/cs_pkg.sv
// Package: sizes and the state encoding for the counting sort block.
`timescale 1ns / 1ps
package cs_pkg;

  localparam int KEY_VALUES = 256;
  localparam int MAX_ITEMS  = 64;

  localparam int KEY_W    = 8;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = $clog2(KEY_VALUES);
  localparam int HELD_W   = $clog2(MAX_ITEMS + 1);

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [HELD_W-1:0] held_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_INC   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_EMPTY = 7'b1000000
  } state_t;

endpackage

FILE: design/counting_sort.sv
// Top level of the counting sort block: histogram sequencer and result register.
`timescale 1ns / 1ps
// Counting sort of 8-bit keys. Send keys one word at a time on the item
// channel, marking the final key of a set with last_item. For each counted key
// its histogram bucket is read from the RAM as the key is taken and the
// incremented count is written back in S_INC, so item_stall is high on the
// cycle after it; a dropped key writes nothing. After the last key the block
// walks the buckets from zero up to the largest key seen: each bucket is read
// in S_RD and cleared in S_LOAD, then yields its results one word at a time in
// S_EMIT as the output register frees, in ascending order on the result
// channel with last_result on the final word and overflow set there if any
// key was dropped because the set exceeded MAX_ITEMS keys. A set whose keys
// were all dropped yields a single word with key 0, last_result 1 and
// overflow 1. After reset the histogram RAM is cleared in a pass over all
// KEY_VALUES (256) buckets, during which no key is taken. A finished word
// waits in the output register while the block takes keys of the next set.
module counting_sort (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  cs_pkg::key_t       key_value,
  input  logic               last_item,
  output logic               result_valid,
  input  logic               result_stall,
  output cs_pkg::key_t       sorted_key,
  output logic               last_result,
  output logic               overflow
);
  import cs_pkg::*;

  state_t state;
  addr_t  idx;
  addr_t  key_reg;
  logic   last_reg;
  cnt_t   cnt;
  key_t   largest_key;
  held_t  items_held;
  logic   dropped_flag;

  logic   ram_we;
  addr_t  ram_waddr;
  cnt_t   ram_wdata;
  addr_t  ram_raddr;
  cnt_t   ram_rdata;

  logic   accept;
  logic   drop;
  logic   out_free;
  logic   at_largest;
  logic   load_word;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign drop       = (32'(key_value) >= KEY_VALUES) || (32'(items_held) >= MAX_ITEMS);
  assign out_free   = !result_valid || !result_stall;
  assign at_largest = (idx == ADDR_W'(largest_key));
  assign load_word  = ((state == S_EMIT) || (state == S_EMPTY)) && out_free;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    ram_raddr = (state == S_IDLE) ? ADDR_W'(key_value) : idx;
    case (state)
      S_CLEAR: ram_we = 1'b1;
      S_INC: begin
        ram_we    = 1'b1;
        ram_waddr = key_reg;
        ram_wdata = ram_rdata + cnt_t'(1);
      end
      S_LOAD:  ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  cs_ram #(
    .WIDTH(CNT_W),
    .DEPTH(KEY_VALUES)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      idx          <= '0;
      largest_key  <= '0;
      items_held   <= '0;
      dropped_flag <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load_word) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (idx == addr_t'(KEY_VALUES - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + addr_t'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            key_reg  <= ADDR_W'(key_value);
            last_reg <= last_item;
            idx      <= '0;
            if (!drop) begin
              state <= S_INC;
              if (key_value > largest_key) begin
                largest_key <= key_value;
              end
            end else begin
              dropped_flag <= 1'b1;
              if (last_item) begin
                state <= (items_held == '0) ? S_EMPTY : S_RD;
              end
            end
          end
        end
        S_INC: begin
          items_held <= items_held + held_t'(1);
          state      <= last_reg ? S_RD : S_IDLE;
        end
        S_RD:    state <= S_LOAD;
        S_LOAD: begin
          // bucket is cleared by the write issued in this cycle
          cnt <= ram_rdata;
          if (ram_rdata != '0) begin
            state <= S_EMIT;
          end else begin
            idx   <= idx + addr_t'(1);
            state <= S_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            sorted_key   <= KEY_W'(idx);
            last_result  <= at_largest && (cnt == cnt_t'(1));
            overflow     <= at_largest && (cnt == cnt_t'(1)) && dropped_flag;
            cnt          <= cnt - cnt_t'(1);
            if (cnt == cnt_t'(1)) begin
              if (at_largest) begin
                idx          <= '0;
                largest_key  <= '0;
                items_held   <= '0;
                dropped_flag <= 1'b0;
                state        <= S_IDLE;
              end else begin
                idx   <= idx + addr_t'(1);
                state <= S_RD;
              end
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            sorted_key   <= '0;
            last_result  <= 1'b1;
            overflow     <= 1'b1;
            largest_key  <= '0;
            items_held   <= '0;
            dropped_flag <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_held_cap: assert property (@(posedge clk) disable iff (rst)
    32'(items_held) <= MAX_ITEMS)
    else $error("histogram holds more keys than capacity");

  a_emit_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (cnt != '0))
    else $error("emitting from an empty bucket");

  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && overflow) |-> last_result)
    else $error("overflow flagged on a word that is not the last");

  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result && $rose(result_valid)) |-> (items_held == '0))
    else $error("set state not cleared after final word");
`endif

endmodule

FILE: design/cs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
